@@ hw/rtl/relay_switch_sequencer_defines.svh @@
// Assertion macros shared by the relay switch sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RELAY_SWITCH_SEQUENCER_DEFINES_SVH
`define RELAY_SWITCH_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rss assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rss assertion failed");

`else

`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/rss_pkg.sv @@
`timescale 1ns / 1ps
// Types, codes and reset constants of the relay switch sequencer.
// No dependencies; used by relay_switch_sequencer.
package rss_pkg;

    // Channel count default.
    localparam int CHANNELS_DEF = 2;

    // Request modes.
    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_REQ_ON    = 2'd1;
    localparam logic [1:0] MODE_REQ_OFF   = 2'd2;
    localparam logic [1:0] MODE_FORCE_OFF = 2'd3;

    // Drive commands.
    localparam logic [1:0] DRIVE_NONE = 2'd0;
    localparam logic [1:0] DRIVE_ON   = 2'd1;
    localparam logic [1:0] DRIVE_OFF  = 2'd2;

    // Reported relay state.
    localparam logic [1:0] RELAY_OFF   = 2'd0;
    localparam logic [1:0] RELAY_ON    = 2'd1;
    localparam logic [1:0] RELAY_ERROR = 2'd2;

    // Sequencer actions.
    localparam logic [1:0] ACT_IDLE   = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_OFF    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Sequencer steps.
    localparam logic [1:0] STEP_WAIT   = 2'd0;
    localparam logic [1:0] STEP_DRIVE  = 2'd1;
    localparam logic [1:0] STEP_SETTLE = 2'd2;
    localparam logic [1:0] STEP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SUPPLY_WAIT = 2'd0;
    localparam logic [1:0] CFG_SETTLE      = 2'd1;
    localparam logic [1:0] CFG_AUX_OFF     = 2'd2;
    localparam logic [1:0] CFG_AUX_ON      = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] SUPPLY_WAIT_RST = 16'd100;
    localparam logic [7:0]  SETTLE_RST      = 8'd20;
    localparam logic [7:0]  AUX_OFF_RST     = 8'd5;
    localparam logic [7:0]  AUX_ON_RST      = 8'd5;

    // Saturation point of the contact filter counter.
    localparam logic [7:0] FILTER_MAX = 8'hff;

    typedef struct packed {
        logic [1:0] mode;
        logic       channel;
        logic       supply_ok;
        logic       aux_contact;
    } t_in_item;

    typedef struct packed {
        logic       out_channel;
        logic [1:0] drive_cmd;
        logic       clear_on_flag;
        logic [1:0] relay_state;
        logic       fault_raised;
    } t_out_item;

    // Per-channel state kept in memory. The filter result is consumed in the
    // same step that produces it, so it is never stored.
    typedef struct packed {
        logic        switching;
        logic        wanted_on;
        logic        actual_on;
        logic [1:0]  seq_step;
        logic [1:0]  action;
        logic [15:0] wait_count;
        logic [7:0]  settle_count;
        logic        filter_last;
        logic [7:0]  filter_count;
        logic        faulted;
    } t_chan_state;

endpackage

@@ hw/rtl/rss_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by relay_switch_sequencer.
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/relay_switch_sequencer.sv @@
`timescale 1ns / 1ps
// Relay switch sequencer: per-channel switching sequence and contact check.
// Depends on rss_pkg, rss_ram and relay_switch_sequencer_defines.svh.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_in_data) carries one request:
//   a tick, a request on, a request off or a force drive off for a channel.
// - Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one result per request, in request order.
// - Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
//   i_cfg_data) is always ready; write it only while no request is in flight.
// - Pipeline: the edge that accepts a request also reads the channel state
//   memory; the update stage then registers the updated state and the
//   result once the result register is free.
// - Throughput: one request per cycle unless i_out_ready stalls, set by the
//   single read-modify-write of the state memory; back-to-back requests to
//   the same channel take the updated state through a forwarding register.
// - Reset: configuration returns to its defaults and every channel reads
//   as idle, off and fault free through per-channel valid bits.
// - Stall: while the receiver holds i_out_ready low, one more request is
//   accepted into the update stage, then o_in_ready drops until the result
//   register drains.
`include "relay_switch_sequencer_defines.svh"

module relay_switch_sequencer #(
    parameter int CHANNELS = rss_pkg::CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rss_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rss_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    import rss_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = $bits(t_chan_state);

    logic [15:0]     r_cfg_supply_wait;
    logic [7:0]      r_cfg_settle;
    logic [7:0]      r_cfg_aux_off;
    logic [7:0]      r_cfg_aux_on;

    logic            in_acc;
    logic            in_range_in;
    logic [AW-1:0]   rd_addr;

    logic            r_s1_vld;
    t_in_item        r_s1_item;
    logic [AW-1:0]   r_s1_addr;
    logic            r_s1_in_range;
    logic            s1_adv;

    logic            r_out_vld;
    t_out_item       r_out_item;

    logic [CHANNELS-1:0] r_chan_vld;
    logic            r_fwd_vld;
    logic [AW-1:0]   r_fwd_addr;
    t_chan_state     r_fwd_data;

    logic [SW-1:0]   ram_rdata;
    logic            ram_we;
    t_chan_state     cur_state;
    t_chan_state     n_state;
    t_out_item       n_result;

    // Configuration registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_supply_wait <= SUPPLY_WAIT_RST;
            r_cfg_settle      <= SETTLE_RST;
            r_cfg_aux_off     <= AUX_OFF_RST;
            r_cfg_aux_on      <= AUX_ON_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SUPPLY_WAIT: r_cfg_supply_wait <= i_cfg_data;
                CFG_SETTLE:      r_cfg_settle      <= i_cfg_data[7:0];
                CFG_AUX_OFF:     r_cfg_aux_off     <= i_cfg_data[7:0];
                CFG_AUX_ON:      r_cfg_aux_on      <= i_cfg_data[7:0];
            endcase
        end
    end

    // Handshake: the update stage moves when the result register is free.
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_range_in = (32'(i_in_data.channel) < CHANNELS);
    assign rd_addr     = in_range_in ? AW'(i_in_data.channel) : '0;

    // State memory: read at accept, written back from the update stage.
    assign ram_we = s1_adv && r_s1_in_range;

    rss_ram #(
        .WIDTH (SW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_state),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Update stage request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item     <= i_in_data;
            r_s1_addr     <= rd_addr;
            r_s1_in_range <= in_range_in;
        end
    end

    // Valid bits stand in for the reset of the state memory; the forwarding
    // register holds the last write, which the memory read may have missed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_vld <= '0;
            r_fwd_vld  <= 1'b0;
        end else if (ram_we) begin
            r_chan_vld[r_s1_addr] <= 1'b1;
            r_fwd_vld             <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_state;
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_state = r_fwd_data;
        end else if (r_chan_vld[r_s1_addr]) begin
            cur_state = t_chan_state'(ram_rdata);
        end else begin
            cur_state = '0;
        end
    end

    // Channel update: requests, sequencer step and contact filter.
    always_comb begin
        logic [1:0] drive;
        logic       clr;
        logic       fault;
        logic [7:0] need;

        n_state = cur_state;
        drive   = DRIVE_NONE;
        clr     = 1'b0;
        fault   = 1'b0;
        need    = cur_state.actual_on ? r_cfg_aux_on : r_cfg_aux_off;

        unique case (r_s1_item.mode)
            MODE_REQ_ON: begin
                n_state.wanted_on = 1'b1;
            end
            MODE_REQ_OFF: begin
                n_state.wanted_on = 1'b0;
            end
            MODE_FORCE_OFF: begin
                drive = DRIVE_OFF;
            end
            MODE_TICK: begin
                if (!cur_state.switching) begin
                    // Start a switch when wanted and actual disagree.
                    if (cur_state.wanted_on != cur_state.actual_on) begin
                        n_state.switching = 1'b1;
                        n_state.action    = cur_state.wanted_on ? ACT_ON : ACT_OFF;
                    end
                end else begin
                    if (cur_state.action != ACT_IDLE) begin
                        unique case (cur_state.seq_step)
                            STEP_WAIT: begin
                                if (cur_state.action == ACT_ON) begin
                                    if (r_s1_item.supply_ok) begin
                                        n_state.seq_step = STEP_DRIVE;
                                    end else if (cur_state.wait_count > r_cfg_supply_wait) begin
                                        // Supply timed out: drop the on request.
                                        n_state.wait_count = '0;
                                        n_state.wanted_on  = 1'b0;
                                        n_state.action     = ACT_IDLE;
                                    end else begin
                                        n_state.wait_count = cur_state.wait_count + 16'd1;
                                    end
                                end else if (cur_state.action == ACT_OFF) begin
                                    n_state.seq_step = STEP_DRIVE;
                                end
                            end
                            STEP_DRIVE: begin
                                if (cur_state.action == ACT_OFF) begin
                                    drive             = DRIVE_OFF;
                                    n_state.actual_on = 1'b0;
                                    n_state.seq_step  = STEP_SETTLE;
                                end else if (cur_state.action == ACT_ON) begin
                                    drive             = DRIVE_ON;
                                    n_state.actual_on = 1'b1;
                                    n_state.seq_step  = STEP_SETTLE;
                                end
                            end
                            STEP_SETTLE: begin
                                if (cur_state.action == ACT_ON) begin
                                    if (cur_state.settle_count > r_cfg_settle) begin
                                        n_state.settle_count = '0;
                                        clr                  = 1'b1;
                                        n_state.action       = ACT_IDLE;
                                    end else begin
                                        n_state.settle_count = cur_state.settle_count + 8'd1;
                                    end
                                end else begin
                                    clr            = 1'b1;
                                    n_state.action = ACT_IDLE;
                                end
                            end
                            STEP_UNUSED: begin
                                n_state.seq_step = STEP_WAIT;
                            end
                        endcase
                    end
                    if (n_state.action == ACT_IDLE) begin
                        n_state.switching = 1'b0;
                        n_state.seq_step  = STEP_WAIT;
                    end
                end

                // Steady-state contact filter, run on the updated state.
                if (n_state.wanted_on == n_state.actual_on) begin
                    need = n_state.actual_on ? r_cfg_aux_on : r_cfg_aux_off;
                    if (r_s1_item.aux_contact == n_state.filter_last) begin
                        if (n_state.filter_count != FILTER_MAX) begin
                            n_state.filter_count = n_state.filter_count + 8'd1;
                        end
                    end else begin
                        n_state.filter_last  = r_s1_item.aux_contact;
                        n_state.filter_count = 8'd1;
                    end
                    if (n_state.filter_count >= need) begin
                        n_state.filter_count = '0;
                        // A filtered level against the relay state is a fault.
                        if (r_s1_item.aux_contact != n_state.actual_on) begin
                            n_state.faulted = 1'b1;
                            fault           = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Result assembly; an absent channel reports zeros beside its channel number.
        n_result.out_channel = r_s1_item.channel;
        if (r_s1_in_range) begin
            n_result.drive_cmd     = drive;
            n_result.clear_on_flag = clr;
            n_result.relay_state   = n_state.faulted ? RELAY_ERROR :
                                     (n_state.actual_on ? RELAY_ON : RELAY_OFF);
            n_result.fault_raised  = fault;
        end else begin
            n_result.drive_cmd     = DRIVE_NONE;
            n_result.clear_on_flag = 1'b0;
            n_result.relay_state   = RELAY_OFF;
            n_result.fault_raised  = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

    // Checks on the update logic and the pipeline.
    `RSS_ASSERT_IMP(a_clr_no_drive, i_clk, i_rst_n,
        r_out_vld && r_out_item.clear_on_flag, r_out_item.drive_cmd == DRIVE_NONE)
    `RSS_ASSERT_IMP(a_fault_is_error, i_clk, i_rst_n,
        r_out_vld && r_out_item.fault_raised, r_out_item.relay_state == RELAY_ERROR)
    `RSS_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n,
        r_s1_vld && !s1_adv, r_s1_vld && $stable(r_s1_item))
    `RSS_ASSERT_IMP(a_fwd_written, i_clk, i_rst_n,
        r_fwd_vld, r_chan_vld[r_fwd_addr])

endmodule
